>>> rtl/adcmidi_pkg.sv
// shared constants for the adc scan deadband midi cc block
`default_nettype none

package adcmidi_pkg;

    // default parameter values
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 12;

    // field widths fixed by the message format
    localparam int THR_W    = 12;
    localparam int CTRL_W   = 7;
    localparam int MCH_W    = 4;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int VALUE_W  = 7;
    localparam int CHAN_W   = 3;
    localparam int STATUS_W = 8;

    // control-change status byte, channel nibble clear
    localparam logic [STATUS_W-1:0] CC_STATUS = 8'hB0;
    localparam logic [CTRL_W-1:0]   CTRL_MAX  = 7'd127;

    // register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 12'd8;
    localparam logic [CTRL_W-1:0] BASE_CTRL_RST = 7'd80;
    localparam logic [MCH_W-1:0]  MIDI_CH_RST   = 4'd0;
    localparam logic [CNT_W-1:0]  CH_COUNT_RST  = 4'd5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_BASE_CTRL = 2'd1,
        REG_MIDI_CH   = 2'd2,
        REG_CH_COUNT  = 2'd3
    } cfg_reg_t;

endpackage : adcmidi_pkg

`default_nettype wire

>>> rtl/adc_scan_deadband_midi_cc.sv
// top level: round-robin deadband scanner that emits midi control-change words
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | sample
//  out      | out_valid / out_ready| sent, status_byte, controller_number,
//           |                      | control_value, scanned_channel, next_mux_select
//  cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
//  Two register stages: an input stage that also holds the registered read of the
//  last-reported table, and a result register. One word per cycle while out_ready is high;
//  a word passes the input stage, then the result register, which drives out_valid.
//  A table write by the word leaving the input stage is bypassed into the read
//  for the word entering it, so a single-channel scan keeps full rate.
//  Reset clears the scan index, the table valid bits and all handshake state.
//  An output stall holds the result register, then the input stage, then in_ready.
`default_nettype none

module adc_scan_deadband_midi_cc
    import adcmidi_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        sent,
    output logic [STATUS_W-1:0]         status_byte,
    output logic [CTRL_W-1:0]           controller_number,
    output logic [VALUE_W-1:0]          control_value,
    output logic [CHAN_W-1:0]           scanned_channel,
    output logic [CHAN_W-1:0]           next_mux_select
);

    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int SHIFT  = SAMPLE_BITS - VALUE_W;
    localparam logic [7:0] MAX_CH8 = 8'(MAX_CHANNELS);

    // configuration registers
    logic [THR_W-1:0]  threshold_reg;
    logic [CTRL_W-1:0] base_ctrl_reg;
    logic [MCH_W-1:0]  midi_ch_reg;
    logic [CNT_W-1:0]  ch_count_reg;

    // scan state and last-reported table
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       scan_idx_next;
    logic [MAX_CHANNELS-1:0] entry_valid_reg;
    logic [SAMPLE_BITS-1:0] last_mem [MAX_CHANNELS];

    // input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic [IDX_W-1:0]       s1_next_reg;
    logic [SAMPLE_BITS-1:0] s1_prev_rd_reg;
    logic                   s1_prev_hit_reg;

    // result register
    logic                   out_valid_reg;
    logic                   sent_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [CTRL_W-1:0]      ctrl_num_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic [CHAN_W-1:0]      next_sel_reg;

    // handshake control
    logic in_fire;
    logic out_free;
    logic s1_adv;
    logic s1_write;
    logic bypass;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            base_ctrl_reg <= BASE_CTRL_RST;
            midi_ch_reg   <= MIDI_CH_RST;
            ch_count_reg  <= CH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_BASE_CTRL: base_ctrl_reg <= cfg_data[CTRL_W-1:0];
                REG_MIDI_CH:   midi_ch_reg   <= cfg_data[MCH_W-1:0];
                REG_CH_COUNT:  ch_count_reg  <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // next scan index, wrapping at the clamped channel count
    logic [7:0]     active_cnt;
    logic [IDX_W:0] idx_inc;

    always_comb
    begin
        active_cnt = (ch_count_reg == '0) ? 8'd1 : 8'(ch_count_reg);
        if (active_cnt > MAX_CH8)
        begin
            active_cnt = MAX_CH8;
        end
        idx_inc = {1'b0, scan_idx_reg} + 1'b1;
        if (8'(idx_inc) >= active_cnt)
        begin
            scan_idx_next = '0;
        end
        else
        begin
            scan_idx_next = idx_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (in_fire)
        begin
            scan_idx_reg <= scan_idx_next;
        end
    end

    // deadband compare on the input stage
    logic [SAMPLE_BITS-1:0] prev_val;
    logic [SAMPLE_BITS-1:0] abs_diff;
    logic                   send;
    logic [7:0]             ctrl_sum;
    logic [CTRL_W-1:0]      ctrl_sat;

    always_comb
    begin
        prev_val = s1_prev_hit_reg ? s1_prev_rd_reg : '0;
        abs_diff = (s1_sample_reg >= prev_val) ? (s1_sample_reg - prev_val)
                                               : (prev_val - s1_sample_reg);
        send     = CMP_W'(abs_diff) >= CMP_W'(threshold_reg);
        ctrl_sum = 8'(base_ctrl_reg) + 8'(s1_idx_reg);
        ctrl_sat = (ctrl_sum > 8'(CTRL_MAX)) ? CTRL_MAX : ctrl_sum[CTRL_W-1:0];
    end

    assign s1_write = s1_adv && send;
    // the word leaving now updates the entry the incoming word reads
    assign bypass   = s1_write && (s1_idx_reg == scan_idx_reg);

    // table valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (s1_write)
        begin
            entry_valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    // last-reported table write
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            last_mem[s1_idx_reg] <= s1_sample_reg;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload and registered table read with bypass
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg   <= sample;
            s1_idx_reg      <= scan_idx_reg;
            s1_next_reg     <= scan_idx_next;
            s1_prev_rd_reg  <= bypass ? s1_sample_reg : last_mem[scan_idx_reg];
            s1_prev_hit_reg <= bypass || entry_valid_reg[scan_idx_reg];
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            sent_reg     <= send;
            status_reg   <= send ? (CC_STATUS | STATUS_W'(midi_ch_reg)) : '0;
            ctrl_num_reg <= send ? ctrl_sat : '0;
            value_reg    <= send ? VALUE_W'(s1_sample_reg >> SHIFT) : '0;
            chan_reg     <= CHAN_W'(s1_idx_reg);
            next_sel_reg <= CHAN_W'(s1_next_reg);
        end
    end

    // output ports
    assign out_valid         = out_valid_reg;
    assign sent              = sent_reg;
    assign status_byte       = status_reg;
    assign controller_number = ctrl_num_reg;
    assign control_value     = value_reg;
    assign scanned_channel   = chan_reg;
    assign next_mux_select   = next_sel_reg;

endmodule : adc_scan_deadband_midi_cc

`default_nettype wire
